// ----- rtl/hrsp_pkg.sv -----
// ----------------------------------------------------------------------------
// hrsp_pkg
// Codes, character constants and literal lookups for the HTTP request parser.
// ----------------------------------------------------------------------------
package hrsp_pkg;

    // result event codes
    localparam logic [3:0] EV_METHOD   = 4'd0;
    localparam logic [3:0] EV_URI      = 4'd1;
    localparam logic [3:0] EV_VERSION  = 4'd2;
    localparam logic [3:0] EV_HEADER   = 4'd3;
    localparam logic [3:0] EV_HDR_END  = 4'd4;
    localparam logic [3:0] EV_BODY     = 4'd5;
    localparam logic [3:0] ER_METHOD   = 4'd6;
    localparam logic [3:0] ER_VER_MAL  = 4'd7;
    localparam logic [3:0] ER_VER_UNK  = 4'd8;
    localparam logic [3:0] ER_TOO_MANY = 4'd9;
    localparam logic [3:0] ER_CHUNK    = 4'd10;

    // method codes
    localparam logic [3:0] M_GET     = 4'd0;
    localparam logic [3:0] M_POST    = 4'd1;
    localparam logic [3:0] M_PUT     = 4'd2;
    localparam logic [3:0] M_PATCH   = 4'd3;
    localparam logic [3:0] M_HEAD    = 4'd4;
    localparam logic [3:0] M_DELETE  = 4'd5;
    localparam logic [3:0] M_CONNECT = 4'd6;
    localparam logic [3:0] M_OPTIONS = 4'd7;
    localparam logic [3:0] M_TRACE   = 4'd8;

    // body modes
    localparam logic [1:0] BK_EOS     = 2'd0;
    localparam logic [1:0] BK_CL      = 2'd1;
    localparam logic [1:0] BK_CHUNKED = 2'd2;

    // header name match progress codes
    localparam logic [5:0] NM_NONE  = 6'd0;
    localparam logic [5:0] NM_TE    = 6'd17;
    localparam logic [5:0] NM_CL0   = 6'd18;
    localparam logic [5:0] NM_CL    = 6'd31;
    localparam logic [5:0] NM_FAIL  = 6'd32;

    // value match progress codes
    localparam logic [3:0] VM_CHUNKED = 4'd7;
    localparam logic [3:0] VM_FAIL    = 4'd8;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;

    function automatic logic [7:0] to_lower(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic logic [3:0] method_len(input logic [3:0] m);
        case (m)
            M_GET, M_PUT:          return 4'd4;
            M_POST, M_HEAD:        return 4'd5;
            M_PATCH, M_TRACE:      return 4'd6;
            M_DELETE:              return 4'd7;
            M_CONNECT, M_OPTIONS:  return 4'd8;
            default:               return 4'd0;
        endcase
    endfunction

    function automatic logic [7:0] method_char(input logic [3:0] m, input logic [2:0] i);
        logic [63:0] w;
        case (m)
            M_GET:     w = {"GET ", 32'h0};
            M_POST:    w = {"POST ", 24'h0};
            M_PUT:     w = {"PUT ", 32'h0};
            M_PATCH:   w = {"PATCH ", 16'h0};
            M_HEAD:    w = {"HEAD ", 24'h0};
            M_DELETE:  w = {"DELETE ", 8'h0};
            M_CONNECT: w = "CONNECT ";
            M_OPTIONS: w = "OPTIONS ";
            M_TRACE:   w = {"TRACE ", 16'h0};
            default:   w = 64'h0;
        endcase
        return w[8*(7-i) +: 8];
    endfunction

    function automatic logic [7:0] version_char(input logic [3:0] i);
        logic [79:0] w;
        w = {"HTTP/1.x", CH_CR, CH_LF};
        return (i <= 4'd9) ? w[8*(9-i) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] te_char(input logic [5:0] p);
        logic [135:0] w;
        w = "transfer-encoding";
        return (p <= 6'd16) ? w[8*(16-p) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] cl_char(input logic [5:0] k);
        logic [111:0] w;
        w = "content-length";
        return (k <= 6'd13) ? w[8*(13-k) +: 8] : 8'h00;
    endfunction

    function automatic logic [7:0] ch_char(input logic [3:0] p);
        logic [55:0] w;
        w = "chunked";
        return (p <= 4'd6) ? w[8*(6-p) +: 8] : 8'h00;
    endfunction

    // advance the case-insensitive header name match by one lowered byte
    function automatic logic [5:0] name_match(input logic [5:0] p, input logic [7:0] l);
        logic [5:0] k;
        k = p - NM_TE;
        if (p == NM_NONE) begin
            return (l == "t") ? 6'd1 : (l == "c") ? NM_CL0 : NM_FAIL;
        end else if (p < NM_TE) begin
            return (l == te_char(p)) ? p + 6'd1 : NM_FAIL;
        end else if (p >= NM_CL0 && p < NM_CL) begin
            return (l == cl_char(k)) ? p + 6'd1 : NM_FAIL;
        end
        return NM_FAIL;
    endfunction

endpackage

// ----- rtl/http_request_stream_parser_top.sv -----
// ----------------------------------------------------------------------------
// http_request_stream_parser_top
// Byte-wide HTTP/1.x request parser with header spans and body decoding.
// ----------------------------------------------------------------------------
// Takes one request byte per transfer and sustains one byte per cycle: every
// byte updates the parser registers directly and any result lands in a single
// output register. A byte is taken in the same cycle that a waiting result is
// taken; input stalls only while a result waits and downstream holds off. A
// result appears in the cycle after its byte. Input tuser high restarts the
// parser (header limit kept). Results carry the event code in tuser and the
// request-complete flag in tlast. Offsets saturate at 2^OFFSET_BITS-1, lengths
// at 2^LENGTH_BITS-1; both are clamped to the output field widths.
module http_request_stream_parser_top #(
    parameter int MAX_HEADERS = 64,
    parameter int OFFSET_BITS = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [6:0]   i_cfg_wr_data,     // header_limit
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,    // data_byte
    input  logic         i_s_axis_tuser,    // opcode
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // method_code[3:0] version_minor[4] span_start[20:5] span_length[36:21]
    // value_offset[52:37] value_length[68:53] header_index[74:69]
    // body_mode[76:75] length_value[108:77] body_data[116:109] zero[119:117]
    output logic [119:0] o_m_axis_tdata,
    output logic [3:0]   o_m_axis_tuser,    // event_res
    output logic         o_m_axis_tlast     // done_res
);
    import hrsp_pkg::*;

    localparam int OB = OFFSET_BITS;
    localparam int LB = LENGTH_BITS;
    localparam logic [7:0] MaxHdr = 8'(MAX_HEADERS);

    typedef enum logic [12:0] {
        PH_METHOD   = 13'b0000000000001,
        PH_URI      = 13'b0000000000010,
        PH_VERSION  = 13'b0000000000100,
        PH_NAME     = 13'b0000000001000,
        PH_VLEAD    = 13'b0000000010000,
        PH_VALUE    = 13'b0000000100000,
        PH_BODY_CL  = 13'b0000001000000,
        PH_BODY_EOS = 13'b0000010000000,
        PH_CSIZE    = 13'b0000100000000,
        PH_CDATA    = 13'b0001000000000,
        PH_CTAIL    = 13'b0010000000000,
        PH_DONE     = 13'b0100000000000,
        PH_ERROR    = 13'b1000000000000
    } t_phase;

    typedef struct packed {
        logic          lead;
        logic [OB-1:0] vbeg;
        logic [OB-1:0] vlast;
        logic [LB-1:0] len;
        logic [3:0]    vmp;
    } t_val;

    function automatic logic [LB-1:0] sat_mac(input logic [LB-1:0] x, input logic hex,
                                              input logic [3:0] d);
        logic [LB+4:0] p;
        p = hex ? ({5'b0, x} << 4) : (({5'b0, x} << 3) + ({5'b0, x} << 1));
        p = p + (LB+5)'(d);
        return (p[LB+4:LB] != 5'd0) ? {LB{1'b1}} : p[LB-1:0];
    endfunction

    function automatic logic [15:0] clamp16(input logic [63:0] x);
        return (x > 64'hFFFF) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic logic [31:0] clamp32(input logic [63:0] x);
        return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
    endfunction

    // one header value byte: trim tracking and chunked / content-length matching
    function automatic t_val val_step(input t_val v, input logic [7:0] c,
                                      input logic [OB-1:0] o, input logic [1:0] bk,
                                      input logic [5:0] nmp);
        t_val r;
        logic ws;
        r  = v;
        ws = (c == CH_SP) || (c == CH_TAB);
        if (r.lead && ws) return r;
        if (r.lead) begin
            r.lead = 1'b0;
            r.vbeg = o;
            if (bk == BK_EOS && nmp == NM_CL) r.len = '0;
        end
        if (!ws) r.vlast = o;
        if (bk != BK_EOS) return r;
        if (nmp == NM_TE) begin
            if (ws) begin
                if (r.vmp != VM_CHUNKED) r.vmp = VM_FAIL;
            end else begin
                r.vmp = (r.vmp < VM_CHUNKED && to_lower(c) == ch_char(r.vmp))
                        ? r.vmp + 4'd1 : VM_FAIL;
            end
        end else if (nmp == NM_CL) begin
            if (r.vmp == 4'd0 && c >= "0" && c <= "9") r.len = sat_mac(r.len, 1'b0, c[3:0]);
            else r.vmp = VM_FAIL;
        end
        return r;
    endfunction

    t_phase         r_phase, n_phase;
    logic [3:0]     r_lit, n_lit;
    logic [3:0]     r_method, n_method;
    logic           r_ver, n_ver;
    logic [OB-1:0]  r_off, n_off;
    logic [OB-1:0]  r_fs, n_fs;
    logic [OB-1:0]  r_vbeg, n_vbeg;
    logic [OB-1:0]  r_vlast, n_vlast;
    logic [OB-1:0]  r_nend, n_nend;
    logic [OB-1:0]  r_cro, n_cro;
    logic [6:0]     r_hs, n_hs;
    logic [1:0]     r_bk, n_bk;
    logic [LB-1:0]  r_len, n_len;
    logic [LB-1:0]  r_cl, n_cl;
    logic [5:0]     r_nmp, n_nmp;
    logic [3:0]     r_vmp, n_vmp;
    logic           r_car, n_car;
    logic [6:0]     r_hlimit;

    logic           r_out_valid;
    logic [116:0]   r_out_data;
    logic [3:0]     r_out_ev;
    logic           r_out_done;

    logic           acc;
    logic           emit;
    logic [3:0]     ev;
    logic           dn;
    logic [15:0]    sps, spl, vs, vl;
    logic [5:0]     hidx;
    logic [7:0]     bd;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        logic [7:0]    c;
        logic [7:0]    lc;
        logic [3:0]    m;
        logic          bad;
        logic [7:0]    lim;
        logic [LB-1:0] s;
        logic [OB:0]   dv;
        logic [3:0]    vm;
        logic [3:0]    h;
        logic          hok;
        t_val          v;
        n_phase  = r_phase;
        n_lit    = r_lit;
        n_method = r_method;
        n_ver    = r_ver;
        n_fs     = r_fs;
        n_vbeg   = r_vbeg;
        n_vlast  = r_vlast;
        n_nend   = r_nend;
        n_cro    = r_cro;
        n_hs     = r_hs;
        n_bk     = r_bk;
        n_len    = r_len;
        n_cl     = r_cl;
        n_nmp    = r_nmp;
        n_vmp    = r_vmp;
        n_car    = r_car;
        n_off    = (&r_off) ? r_off : r_off + 1'b1;
        emit     = 1'b0;
        ev       = EV_METHOD;
        dn       = 1'b0;
        sps      = '0;
        spl      = '0;
        vs       = '0;
        vl       = '0;
        hidx     = '0;
        bd       = '0;
        c        = i_s_axis_tdata;
        lc       = to_lower(c);
        m        = r_method;
        bad      = 1'b0;
        lim      = ({1'b0, r_hlimit} > MaxHdr) ? MaxHdr : {1'b0, r_hlimit};
        s        = '0;
        dv       = '0;
        vm       = r_vmp;
        h        = '0;
        hok      = 1'b0;
        v        = '{lead: (r_phase == PH_VLEAD), vbeg: r_vbeg, vlast: r_vlast,
                     len: r_len, vmp: r_vmp};
        unique case (r_phase)
            PH_METHOD: begin
                if (r_lit == 4'd0) begin
                    case (c)
                        "G":     m = M_GET;
                        "P":     m = M_POST;
                        "H":     m = M_HEAD;
                        "D":     m = M_DELETE;
                        "C":     m = M_CONNECT;
                        "O":     m = M_OPTIONS;
                        "T":     m = M_TRACE;
                        default: bad = 1'b1;
                    endcase
                end else if (r_method == M_POST && r_lit == 4'd1) begin
                    if (c == "O")      m = M_POST;
                    else if (c == "U") m = M_PUT;
                    else if (c == "A") m = M_PATCH;
                    else               bad = 1'b1;
                end else if (r_lit >= method_len(r_method)
                             || c != method_char(r_method, r_lit[2:0])) begin
                    bad = 1'b1;
                end
                if (bad) begin
                    n_phase = PH_ERROR;
                    n_lit   = ER_METHOD;
                    emit    = 1'b1;
                    ev      = ER_METHOD;
                end else begin
                    n_method = m;
                    n_lit    = r_lit + 4'd1;
                    if (r_lit + 4'd1 == method_len(m)) begin
                        emit    = 1'b1;
                        ev      = EV_METHOD;
                        n_phase = PH_URI;
                        n_fs    = (&r_off) ? r_off : r_off + 1'b1;
                    end
                end
            end
            PH_URI: begin
                if (c == CH_SP) begin
                    emit    = 1'b1;
                    ev      = EV_URI;
                    sps     = clamp16(64'(r_fs));
                    spl     = clamp16(64'(r_off - r_fs));
                    n_phase = PH_VERSION;
                    n_lit   = '0;
                end
            end
            PH_VERSION: begin
                if (r_lit > 4'd9) begin
                    bad = 1'b1;
                    ev  = ER_VER_MAL;
                end else if (r_lit == 4'd7) begin
                    if (c == "0" || c == "1") n_ver = c[0];
                    else begin
                        bad = 1'b1;
                        ev  = ER_VER_UNK;
                    end
                end else if (c != version_char(r_lit)) begin
                    bad = 1'b1;
                    ev  = (r_lit == 4'd5) ? ER_VER_UNK : ER_VER_MAL;
                end
                if (bad) begin
                    n_phase = PH_ERROR;
                    n_lit   = ev;
                    emit    = 1'b1;
                end else if (r_lit == 4'd9) begin
                    emit    = 1'b1;
                    ev      = EV_VERSION;
                    n_phase = PH_NAME;
                    n_lit   = '0;
                    n_fs    = (&r_off) ? r_off : r_off + 1'b1;
                    n_nmp   = NM_NONE;
                    n_car   = 1'b0;
                end else begin
                    n_lit = r_lit + 4'd1;
                end
            end
            PH_NAME: begin
                if (r_lit == 4'd1 && c == CH_LF) begin
                    // blank line: headers end, pick the body mode
                    emit  = 1'b1;
                    ev    = EV_HDR_END;
                    n_car = 1'b0;
                    if (r_bk == BK_CL) begin
                        if (r_len == '0) begin
                            n_phase = PH_DONE;
                            dn      = 1'b1;
                        end else begin
                            n_cl    = r_len;
                            n_phase = PH_BODY_CL;
                        end
                    end else if (r_bk == BK_CHUNKED) begin
                        n_len   = '0;
                        n_cl    = '0;
                        n_vmp   = '0;
                        n_phase = PH_CSIZE;
                    end else begin
                        n_phase = PH_BODY_EOS;
                    end
                end else if (c == CH_COLON) begin
                    n_nend  = r_off;
                    n_phase = PH_VLEAD;
                    n_vmp   = '0;
                    n_car   = 1'b0;
                end else begin
                    n_lit = (r_lit == 4'd0 && c == CH_CR) ? 4'd1 : 4'd2;
                    n_nmp = name_match(r_nmp, lc);
                end
            end
            PH_VLEAD, PH_VALUE: begin
                if (r_car && c == CH_LF) begin
                    n_car = 1'b0;
                    emit  = 1'b1;
                    if ({1'b0, r_hs} >= lim) begin
                        n_phase = PH_ERROR;
                        n_lit   = ER_TOO_MANY;
                        ev      = ER_TOO_MANY;
                    end else begin
                        if (r_bk == BK_EOS && r_phase == PH_VALUE) begin
                            if (r_nmp == NM_TE && r_vmp == VM_CHUNKED) n_bk = BK_CHUNKED;
                            else if (r_nmp == NM_CL)                   n_bk = BK_CL;
                        end
                        ev  = EV_HEADER;
                        sps = clamp16(64'(r_fs));
                        spl = clamp16(64'(r_nend - r_fs));
                        if (r_phase == PH_VALUE) begin
                            dv = {1'b0, r_vlast} - {1'b0, r_vbeg} + 1'b1;
                            vs = clamp16(64'(r_vbeg));
                            vl = clamp16(64'(dv));
                        end else begin
                            vs = clamp16(64'(r_cro));
                        end
                        hidx    = r_hs[5:0];
                        n_hs    = r_hs + 7'd1;
                        n_phase = PH_NAME;
                        n_lit   = '0;
                        n_fs    = (&r_off) ? r_off : r_off + 1'b1;
                        n_nmp   = NM_NONE;
                    end
                end else begin
                    // a held CR not followed by LF is an ordinary value byte
                    if (r_car) v = val_step(v, CH_CR, r_cro, r_bk, r_nmp);
                    n_car = 1'b0;
                    if (c == CH_CR) begin
                        n_car = 1'b1;
                        n_cro = r_off;
                    end else begin
                        v = val_step(v, c, r_off, r_bk, r_nmp);
                    end
                    n_phase = v.lead ? PH_VLEAD : PH_VALUE;
                    n_vbeg  = v.vbeg;
                    n_vlast = v.vlast;
                    n_len   = v.len;
                    n_vmp   = v.vmp;
                end
            end
            PH_BODY_CL: begin
                s     = r_len - r_cl;
                n_cl  = r_cl - 1'b1;
                emit  = 1'b1;
                ev    = EV_BODY;
                sps   = clamp16(64'(s));
                bd    = c;
                if (r_cl - 1'b1 == '0) begin
                    n_phase = PH_DONE;
                    dn      = 1'b1;
                end
            end
            PH_BODY_EOS: begin
                n_len = (&r_len) ? r_len : r_len + 1'b1;
                emit  = 1'b1;
                ev    = EV_BODY;
                sps   = clamp16(64'(r_len));
                bd    = c;
            end
            PH_CSIZE: begin
                if (r_car && c == CH_LF) begin
                    n_car = 1'b0;
                    n_vmp = '0;
                    if (r_cl == '0) begin
                        n_phase = PH_CTAIL;
                        n_lit   = 4'd2;
                    end else begin
                        n_phase = PH_CDATA;
                    end
                end else begin
                    if (r_car) vm = VM_FAIL;
                    n_car = 1'b0;
                    if (c >= "0" && c <= "9") begin
                        h   = c[3:0];
                        hok = 1'b1;
                    end else if (lc >= "a" && lc <= "f") begin
                        h   = 4'(lc - "a" + 8'd10);
                        hok = 1'b1;
                    end
                    if (c == CH_CR) begin
                        n_car = 1'b1;
                        n_vmp = vm;
                    end else if (vm == 4'd0 && hok) begin
                        n_cl  = sat_mac(r_cl, 1'b1, h);
                        n_vmp = vm;
                    end else begin
                        n_vmp = VM_FAIL;
                    end
                end
            end
            PH_CDATA: begin
                n_len = (&r_len) ? r_len : r_len + 1'b1;
                n_cl  = r_cl - 1'b1;
                emit  = 1'b1;
                ev    = EV_BODY;
                sps   = clamp16(64'(r_len));
                bd    = c;
                if (r_cl - 1'b1 == '0) begin
                    n_phase = PH_CTAIL;
                    n_lit   = '0;
                end
            end
            PH_CTAIL: begin
                if (c != (r_lit[0] ? CH_LF : CH_CR)) begin
                    n_phase = PH_ERROR;
                    n_lit   = ER_CHUNK;
                    emit    = 1'b1;
                    ev      = ER_CHUNK;
                end else if (r_lit == 4'd1) begin
                    n_phase = PH_CSIZE;
                    n_cl    = '0;
                    n_vmp   = '0;
                    n_car   = 1'b0;
                end else if (r_lit >= 4'd3) begin
                    n_phase = PH_DONE;
                    emit    = 1'b1;
                    ev      = EV_HDR_END;
                    dn      = 1'b1;
                end else begin
                    n_lit = r_lit + 4'd1;
                end
            end
            PH_ERROR: begin
                emit = 1'b1;
                ev   = r_lit;
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (acc && i_s_axis_tuser)) begin
            r_phase  <= PH_METHOD;
            r_lit    <= '0;
            r_method <= '0;
            r_ver    <= 1'b1;
            r_off    <= '0;
            r_fs     <= '0;
            r_vbeg   <= '0;
            r_vlast  <= '0;
            r_nend   <= '0;
            r_cro    <= '0;
            r_hs     <= '0;
            r_bk     <= BK_EOS;
            r_len    <= '0;
            r_cl     <= '0;
            r_nmp    <= '0;
            r_vmp    <= '0;
            r_car    <= 1'b0;
        end else if (acc) begin
            r_phase  <= n_phase;
            r_lit    <= n_lit;
            r_method <= n_method;
            r_ver    <= n_ver;
            r_off    <= n_off;
            r_fs     <= n_fs;
            r_vbeg   <= n_vbeg;
            r_vlast  <= n_vlast;
            r_nend   <= n_nend;
            r_cro    <= n_cro;
            r_hs     <= n_hs;
            r_bk     <= n_bk;
            r_len    <= n_len;
            r_cl     <= n_cl;
            r_nmp    <= n_nmp;
            r_vmp    <= n_vmp;
            r_car    <= n_car;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hlimit    <= 7'd64;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) r_hlimit <= i_cfg_wr_data;
            if (acc && !i_s_axis_tuser && emit) r_out_valid <= 1'b1;
            else if (i_m_axis_tready)             r_out_valid <= 1'b0;
        end
    end

    // hold the result until taken; load a new one only with an accepted byte
    always_ff @(posedge i_clk) begin
        if (acc && !i_s_axis_tuser && emit) begin
            r_out_ev   <= ev;
            r_out_done <= dn;
            r_out_data <= {bd, clamp32(64'(n_len)), n_bk, hidx, vl, vs, spl, sps,
                           n_ver, n_method};
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {3'b000, r_out_data};
    assign o_m_axis_tuser  = r_out_ev;
    assign o_m_axis_tlast  = r_out_done;

endmodule

// ----- sim/hrsp_checker.sv -----
// ----------------------------------------------------------------------------
// hrsp_checker
// Watches both stream channels of the request parser, keeps its own copy of
// the parser state, predicts every result and compares it as a whole.
// ----------------------------------------------------------------------------
module hrsp_checker (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [6:0]   i_cfg_wr_data,
    input  logic         i_s_tvalid,
    input  logic         i_s_tready,
    input  logic [7:0]   i_s_tdata,
    input  logic         i_s_tuser,
    input  logic         i_m_tvalid,
    input  logic         i_m_tready,
    input  logic [119:0] i_m_tdata,
    input  logic [3:0]   i_m_tuser,
    input  logic         i_m_tlast,
    output int           o_pending,
    output int           o_errors
);
    import hrsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] LEN_MAX = 64'hFFFF_FFFF;
    localparam logic [31:0] OFF_MAX = 32'hFFFF;

    typedef enum logic [3:0] {
        P_METHOD, P_URI, P_VERSION, P_NAME, P_VLEAD, P_VALUE, P_BODY_CL,
        P_BODY_EOS, P_CSIZE, P_CDATA, P_CTAIL, P_DONE, P_ERROR
    } t_chk_phase;

    // laid out so that it equals {tuser, tlast, tdata}
    typedef struct packed {
        logic [3:0]  ev;
        logic        done;
        logic [2:0]  pad;
        logic [7:0]  bdata;
        logic [31:0] lenv;
        logic [1:0]  mode;
        logic [5:0]  hidx;
        logic [15:0] vlen;
        logic [15:0] vst;
        logic [15:0] slen;
        logic [15:0] sst;
        logic        ver;
        logic [3:0]  meth;
    } t_parse_result;

    string method_words[9] = '{"GET ", "POST ", "PUT ", "PATCH ", "HEAD ", "DELETE ",
                               "CONNECT ", "OPTIONS ", "TRACE "};
    string version_word = "HTTP/1.x\r\n";
    string te_word = "transfer-encoding";
    string cl_word = "content-length";
    string ch_word = "chunked";

    t_parse_result result_q[$];
    t_parse_result res;
    int unsigned   limit_reg;
    t_chk_phase    ph;
    logic [3:0]    lit, meth;
    logic          ver, cr_seen;
    logic [31:0]   boff, fstart, vbeg, vlast, nend, croff;
    int unsigned   nseen;
    logic [1:0]    bkind;
    logic [63:0]   lcnt, cleft;
    logic [5:0]    nmp;
    logic [3:0]    vmp;
    int            mismatches = 0;

    assign o_pending = result_q.size();
    assign o_errors  = mismatches;

    function automatic logic [31:0] nxt(input logic [31:0] o);
        return (o < OFF_MAX) ? o + 1 : o;
    endfunction

    function automatic logic [15:0] clip16(input logic [63:0] x);
        return (x > 64'hFFFF) ? 16'hFFFF : x[15:0];
    endfunction

    function automatic logic [63:0] mac(input logic [63:0] x, input int base, input int d);
        if (x > (LEN_MAX - d) / base) return LEN_MAX;
        return x * base + d;
    endfunction

    function automatic logic [7:0] low(input logic [7:0] c);
        return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function automatic int hexv(input logic [7:0] c);
        logic [7:0] l;
        l = low(c);
        if (c >= "0" && c <= "9") return c - "0";
        if (l >= "a" && l <= "f") return l - "a" + 10;
        return -1;
    endfunction

    function automatic void clear_parser();
        ph = P_METHOD; lit = 0; meth = 0; ver = 1; boff = 0; fstart = 0;
        vbeg = 0; vlast = 0; nend = 0; croff = 0; nseen = 0; bkind = BK_EOS;
        lcnt = 0; cleft = 0; nmp = NM_NONE; vmp = 0; cr_seen = 0;
    endfunction

    function automatic void post(input logic [3:0] ev, input logic done);
        res = '0;
        res.ev = ev; res.done = done; res.meth = meth; res.ver = ver;
        res.mode = bkind; res.lenv = lcnt[31:0];
    endfunction

    function automatic bit raise(input logic [3:0] code);
        ph = P_ERROR; lit = code;
        post(code, 1'b0);
        return 1;
    endfunction

    function automatic void begin_line(input logic [31:0] off);
        ph = P_NAME; lit = 0; fstart = nxt(off); nmp = NM_NONE; cr_seen = 0;
    endfunction

    function automatic void track_name(input logic [7:0] c);
        logic [7:0] l;
        l = low(c);
        if (nmp == NM_NONE) nmp = (l == "t") ? 6'd1 : (l == "c") ? NM_CL0 : NM_FAIL;
        else if (nmp < NM_TE) nmp = (l == te_word[nmp]) ? nmp + 1 : NM_FAIL;
        else if (nmp >= NM_CL0 && nmp < NM_CL)
            nmp = (l == cl_word[nmp - NM_TE]) ? nmp + 1 : NM_FAIL;
        else nmp = NM_FAIL;
    endfunction

    function automatic void take_value(input logic [7:0] c, input logic [31:0] o);
        bit ws;
        ws = (c == CH_SP || c == CH_TAB);
        if (ph == P_VLEAD) begin
            if (ws) return;
            ph = P_VALUE;
            vbeg = o;
            if (bkind == BK_EOS && nmp == NM_CL) lcnt = 0;
        end
        if (!ws) vlast = o;
        if (bkind != BK_EOS) return;
        if (nmp == NM_TE) begin
            if (ws) begin
                if (vmp != VM_CHUNKED) vmp = VM_FAIL;
            end else begin
                vmp = (vmp < VM_CHUNKED && low(c) == ch_word[vmp]) ? vmp + 1 : VM_FAIL;
            end
        end else if (nmp == NM_CL) begin
            if (vmp == 0 && c >= "0" && c <= "9") lcnt = mac(lcnt, 10, c - "0");
            else vmp = VM_FAIL;
        end
    endfunction

    function automatic bit finish_header(input logic [31:0] off);
        int unsigned lim;
        logic [31:0] d;
        lim = (limit_reg > 64) ? 64 : limit_reg;
        if (nseen >= lim) return raise(ER_TOO_MANY);
        if (bkind == BK_EOS && ph == P_VALUE) begin
            if (nmp == NM_TE && vmp == VM_CHUNKED) bkind = BK_CHUNKED;
            else if (nmp == NM_CL) bkind = BK_CL;
        end
        post(EV_HEADER, 1'b0);
        res.sst = clip16(fstart);
        d = nend - fstart;
        res.slen = clip16(d);
        if (ph == P_VALUE) begin
            d = vlast - vbeg;
            res.vst = clip16(vbeg);
            res.vlen = clip16(64'(d) + 1);
        end else begin
            res.vst = clip16(croff);
        end
        res.hidx = nseen[5:0];
        nseen++;
        begin_line(off);
        return 1;
    endfunction

    function automatic bit finish_headers();
        logic done;
        done = 0;
        cr_seen = 0;
        if (bkind == BK_CL) begin
            if (lcnt == 0) begin
                ph = P_DONE; done = 1;
            end else begin
                cleft = lcnt; ph = P_BODY_CL;
            end
        end else if (bkind == BK_CHUNKED) begin
            lcnt = 0; cleft = 0; vmp = 0; ph = P_CSIZE;
        end else begin
            ph = P_BODY_EOS;
        end
        post(EV_HDR_END, done);
        return 1;
    endfunction

    function automatic bit body_byte(input logic [63:0] pos, input logic [7:0] c,
                                     input logic done);
        post(EV_BODY, done);
        res.sst = clip16(pos);
        res.bdata = c;
        return 1;
    endfunction

    function automatic bit parse_byte(input logic [7:0] c, input logic [31:0] off);
        logic [63:0] s;
        int h;
        case (ph)
            P_METHOD: begin
                if (lit == 0) begin
                    case (c)
                        "G": meth = M_GET;
                        "P": meth = M_POST;
                        "H": meth = M_HEAD;
                        "D": meth = M_DELETE;
                        "C": meth = M_CONNECT;
                        "O": meth = M_OPTIONS;
                        "T": meth = M_TRACE;
                        default: return raise(ER_METHOD);
                    endcase
                end else if (meth == M_POST && lit == 1) begin
                    if (c == "O") meth = M_POST;
                    else if (c == "U") meth = M_PUT;
                    else if (c == "A") meth = M_PATCH;
                    else return raise(ER_METHOD);
                end else if (lit >= method_words[meth].len() || c != method_words[meth][lit]) begin
                    return raise(ER_METHOD);
                end
                lit++;
                if (lit == method_words[meth].len()) begin
                    post(EV_METHOD, 1'b0);
                    ph = P_URI;
                    fstart = nxt(off);
                    return 1;
                end
                return 0;
            end
            P_URI: begin
                if (c != CH_SP) return 0;
                post(EV_URI, 1'b0);
                s = 64'(off - fstart);
                res.sst = clip16(fstart);
                res.slen = clip16(s[31:0]);
                ph = P_VERSION;
                lit = 0;
                return 1;
            end
            P_VERSION: begin
                if (lit > 9) return raise(ER_VER_MAL);
                if (lit == 7) begin
                    if (c == "0" || c == "1") ver = c[0];
                    else return raise(ER_VER_UNK);
                end else if (c != version_word[lit]) begin
                    return raise(lit == 5 ? ER_VER_UNK : ER_VER_MAL);
                end
                if (lit == 9) begin
                    post(EV_VERSION, 1'b0);
                    begin_line(off);
                    return 1;
                end
                lit++;
                return 0;
            end
            P_NAME: begin
                if (lit == 1 && c == CH_LF) return finish_headers();
                if (c == CH_COLON) begin
                    nend = off; ph = P_VLEAD; vmp = 0; cr_seen = 0;
                    return 0;
                end
                lit = (lit == 0 && c == CH_CR) ? 4'd1 : 4'd2;
                track_name(c);
                return 0;
            end
            P_VLEAD, P_VALUE: begin
                if (cr_seen) begin
                    cr_seen = 0;
                    if (c == CH_LF) return finish_header(off);
                    // bare CR is an ordinary value byte
                    take_value(CH_CR, croff);
                end
                if (c == CH_CR) begin
                    cr_seen = 1; croff = off;
                    return 0;
                end
                take_value(c, off);
                return 0;
            end
            P_BODY_CL: begin
                s = lcnt - cleft;
                cleft--;
                if (cleft == 0) begin
                    ph = P_DONE;
                    return body_byte(s, c, 1'b1);
                end
                return body_byte(s, c, 1'b0);
            end
            P_BODY_EOS: begin
                s = lcnt;
                if (lcnt != LEN_MAX) lcnt++;
                return body_byte(s, c, 1'b0);
            end
            P_CSIZE: begin
                if (cr_seen) begin
                    cr_seen = 0;
                    if (c == CH_LF) begin
                        vmp = 0;
                        if (cleft == 0) begin
                            ph = P_CTAIL; lit = 2;
                        end else begin
                            ph = P_CDATA;
                        end
                        return 0;
                    end
                    vmp = VM_FAIL;
                end
                if (c == CH_CR) begin
                    cr_seen = 1;
                    return 0;
                end
                h = hexv(c);
                if (vmp == 0 && h >= 0) cleft = mac(cleft, 16, h);
                else vmp = VM_FAIL;
                return 0;
            end
            P_CDATA: begin
                s = lcnt;
                if (lcnt < LEN_MAX) lcnt++;
                cleft--;
                if (cleft == 0) begin
                    ph = P_CTAIL; lit = 0;
                end
                return body_byte(s, c, 1'b0);
            end
            P_CTAIL: begin
                if (c != (lit[0] ? CH_LF : CH_CR)) return raise(ER_CHUNK);
                if (lit == 1) begin
                    ph = P_CSIZE; cleft = 0; vmp = 0; cr_seen = 0;
                    return 0;
                end
                if (lit >= 3) begin
                    ph = P_DONE;
                    post(EV_HDR_END, 1'b1);
                    return 1;
                end
                lit++;
                return 0;
            end
            P_ERROR: begin
                post(lit, 1'b0);
                return 1;
            end
            default: return 0;
        endcase
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            limit_reg = 64;
            result_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: actual %h", {i_m_tuser, i_m_tlast, i_m_tdata});
                end else if (result_q[0] !== {i_m_tuser, i_m_tlast, i_m_tdata}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch: expected %h actual %h",
                                 result_q[0], {i_m_tuser, i_m_tlast, i_m_tdata});
                    void'(result_q.pop_front());
                end else begin
                    void'(result_q.pop_front());
                end
            end
            if (i_cfg_wr_en) limit_reg = i_cfg_wr_data;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    clear_parser();
                end else begin
                    if (parse_byte(i_s_tdata, boff)) result_q.push_back(res);
                    if (boff < OFF_MAX) boff++;
                end
            end
        end
    end

endmodule

// ----- sim/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Feeds the request parser with directed and randomly built HTTP requests,
// well-formed and broken, under several header limits and random flow
// control on both sides; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module testbench;
    import hrsp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic [6:0]   cfg_wr_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tuser = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [119:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;
    int           pending, errors;
    bit           quiet = 0;
    bit           hold_req = 0;
    int           rand_items = 0;
    logic [7:0]   req_q[$];

    always #5 i_clk = ~i_clk;

    http_request_stream_parser_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_axis_tvalid(s_tvalid), .o_s_axis_tready(s_tready),
        .i_s_axis_tdata(s_tdata), .i_s_axis_tuser(s_tuser),
        .o_m_axis_tvalid(m_tvalid), .i_m_axis_tready(m_tready),
        .o_m_axis_tdata(m_tdata), .o_m_axis_tuser(m_tuser), .o_m_axis_tlast(m_tlast)
    );

    hrsp_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(cfg_wr_en), .i_cfg_wr_data(cfg_wr_data),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_pending(pending), .o_errors(errors)
    );

    initial begin
        #2_000_000;
        $display("testbench failed");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (400) @(negedge i_clk);
                hold_req = 0;
                m_tready <= 1'b1;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_item(input logic op, input logic [7:0] b);
        if (!quiet && $urandom_range(0, 7) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= b;
        do @(posedge i_clk); while (!s_tready);
        @(negedge i_clk);
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) req_q.push_back(s[i]);
    endtask

    function automatic logic [7:0] mixcase(input logic [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1)) return c - 8'd32;
        return c;
    endfunction

    task automatic push_mixed(input string s);
        for (int i = 0; i < s.len(); i++) req_q.push_back(mixcase(s[i]));
    endtask

    task automatic push_ws();
        repeat ($urandom_range(0, 2)) req_q.push_back($urandom_range(0, 1) ? CH_SP : CH_TAB);
    endtask

    // restart item with random data, then the queued bytes
    task automatic flush_request(input bit counted);
        send_item(1'b1, 8'($urandom));
        if (counted) rand_items++;
        while (req_q.size() > 0) begin
            send_item(1'b0, req_q.pop_front());
            if (counted) rand_items++;
        end
    endtask

    task automatic build_request();
        string mwords[9] = '{"GET ", "POST ", "PUT ", "PATCH ", "HEAD ", "DELETE ",
                             "CONNECT ", "OPTIONS ", "TRACE "};
        string names = "abcdefghijklmnopqrstuvwxyz-0123456789";
        int bm, nh, spec, clen, nchunk, sz, pos;
        req_q.delete();
        if ($urandom_range(0, 9) == 0) begin
            // noise or broken method
            if ($urandom_range(0, 1)) push_str("P");
            repeat ($urandom_range(1, 20)) req_q.push_back(8'($urandom));
            return;
        end
        push_str(mwords[$urandom_range(0, 8)]);
        repeat ($urandom_range(0, 12))
            req_q.push_back($urandom_range(0, 14) == 0 ? CH_CR : 8'($urandom_range(33, 126)));
        push_str(" HTTP/1.");
        req_q.push_back($urandom_range(0, 1) ? "1" : "0");
        push_str("\r\n");
        if ($urandom_range(0, 11) == 0) begin
            pos = $urandom_range(0, req_q.size() - 1);
            req_q[pos] = 8'($urandom);
        end
        bm = $urandom_range(0, 2);
        nh = $urandom_range(bm != 0 ? 1 : 0, 5);
        spec = $urandom_range(0, nh > 0 ? nh - 1 : 0);
        clen = $urandom_range(0, 24);
        for (int i = 0; i < nh; i++) begin
            if (i == spec && bm == 1) begin
                push_mixed("content-length");
                push_str(":");
                push_ws();
                if ($urandom_range(0, 9) != 0) push_str($sformatf("%0d", clen));
                if ($urandom_range(0, 5) == 0) push_str("x9");
            end else if (i == spec && bm == 2) begin
                push_mixed("transfer-encoding");
                push_str(":");
                push_ws();
                push_mixed($urandom_range(0, 4) == 0 ? "gzip" : "chunked");
            end else begin
                if ($urandom_range(0, 5) != 0)
                    repeat ($urandom_range(1, 8))
                        req_q.push_back(mixcase(names[$urandom_range(0, names.len() - 1)]));
                push_str(":");
                push_ws();
                repeat ($urandom_range(0, 8))
                    req_q.push_back($urandom_range(0, 9) == 0 ? CH_CR : 8'($urandom_range(33, 126)));
            end
            push_ws();
            push_str("\r\n");
        end
        push_str("\r\n");
        if (bm == 1) begin
            repeat (clen + $urandom_range(0, 2)) req_q.push_back(8'($urandom));
        end else if (bm == 2) begin
            nchunk = $urandom_range(0, 3);
            repeat (nchunk) begin
                sz = $urandom_range(1, 20);
                push_mixed($sformatf("%0h", sz));
                if ($urandom_range(0, 5) == 0) push_str(";x=1");
                push_str("\r\n");
                repeat (sz) req_q.push_back(8'($urandom));
                push_str($urandom_range(0, 14) == 0 ? "X" : "\r\n");
            end
            push_str($urandom_range(0, 14) == 0 ? "0\r\nX: y\r\n\r\n" : "0\r\n\r\n");
        end else begin
            repeat ($urandom_range(0, 12)) req_q.push_back(8'($urandom));
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (3) @(negedge i_clk);
    endtask

    task automatic write_limit(input logic [6:0] v);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(negedge i_clk);
        cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    initial begin
        logic [6:0] limits[6] = '{7'd0, 7'd1, 7'd3, 7'd127, 7'd5, 7'd64};
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // unknown P method, repeated error, then empty URI, blank-name header
        push_str("PZ!");
        flush_request(0);
        push_str("GET  HTTP/1.1\r\n:\r\n\r\n");
        flush_request(0);

        for (int p = 0; p < 6; p++) begin
            write_limit(limits[p]);
            if (p == 1) hold_req = 1;
            if (p == 5) quiet = 1;
            while (rand_items < (p + 1) * 235) begin
                build_request();
                flush_request(1);
            end
        end

        wait_idle();
        repeat (10) @(negedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("testbench passed");
        end else begin
            $display("testbench failed");
        end
        $finish;
    end

endmodule

// ----- files.f -----
rtl/hrsp_pkg.sv
rtl/http_request_stream_parser_top.sv
sim/hrsp_checker.sv
sim/testbench.sv
